FILE: rtl/core/bounded_min_max_stack_defines.svh
// ----------------------------------------------------------------------------
// bounded_min_max_stack_defines: assertion macros
// Shared property wrappers, clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_MIN_MAX_STACK_DEFINES_SVH
`define BOUNDED_MIN_MAX_STACK_DEFINES_SVH

// same-cycle implication
`define BMMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bmms_pkg.sv
// ----------------------------------------------------------------------------
// bmms_pkg
// Constants, codes and types shared by the min/max stack files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bmms_pkg;

  localparam int DEPTH  = 64;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int CAP_W  = 7;
  localparam int CNT_W  = 7;
  localparam int XW     = (CW > CAP_W) ? CW : CAP_W;
  localparam int DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(5);

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_CAPACITY = 1'b0;   // word index of capacity

  // action codes
  localparam logic [1:0] ACT_QUERY = 2'd0;
  localparam logic [1:0] ACT_PUSH  = 2'd1;
  localparam logic [1:0] ACT_POP   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;

  // one stack level: value plus running min/max of everything at or below it
  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic signed [DATA_W-1:0] lmin;
    logic signed [DATA_W-1:0] lmax;
  } level_t;

endpackage

`default_nettype wire

FILE: rtl/core/bmms_if.sv
// ----------------------------------------------------------------------------
// bmms_if
// Valid/ready channels for stack items and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bmms_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           action;
  logic signed [bmms_pkg::DATA_W-1:0]   push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface bmms_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bmms_pkg::DATA_W-1:0]   top_value;
  logic [bmms_pkg::CNT_W-1:0]           entry_count;
  logic                                 is_empty;
  logic                                 is_full;
  logic signed [bmms_pkg::DATA_W-1:0]   min_value;
  logic signed [bmms_pkg::DATA_W-1:0]   max_value;
  logic [1:0]                           status;

  modport source (output valid, output top_value, output entry_count, output is_empty,
                  output is_full, output min_value, output max_value, output status,
                  input ready);
  modport sink   (input valid, input top_value, input entry_count, input is_empty,
                  input is_full, input min_value, input max_value, input status,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bmms_ram.sv
// ----------------------------------------------------------------------------
// bmms_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic                                        re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bmms_cfg.sv
// ----------------------------------------------------------------------------
// bmms_cfg
// APB register slave holding the capacity register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmms_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bmms_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [bmms_pkg::CFG_DW-1:0]   pwdata,
  output logic      [bmms_pkg::CFG_DW-1:0]   prdata,
  output logic                               pready,
  output logic      [bmms_pkg::CAP_W-1:0]    capacity
);

  logic [bmms_pkg::CAP_W-1:0] cap_r;
  logic [bmms_pkg::CAP_W-1:0] cap_nxt;
  logic                       sel_cap;

  assign pready  = 1'b1;
  assign sel_cap = (paddr[2] == bmms_pkg::REG_CAPACITY);

  always_comb begin
    cap_nxt = cap_r;
    if (psel && penable && pwrite && sel_cap) begin
      cap_nxt = pwdata[bmms_pkg::CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= bmms_pkg::CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_cap) begin
      prdata = {{(bmms_pkg::CFG_DW - bmms_pkg::CAP_W){1'b0}}, cap_r};
    end
  end

  assign capacity = cap_r;

endmodule

`default_nettype wire

FILE: rtl/core/bmms_ctrl.sv
// ----------------------------------------------------------------------------
// bmms_ctrl
// Stack sequencer: reads the level under the top, merges min/max, writes back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_min_max_stack_defines.svh"

module bmms_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [bmms_pkg::CAP_W-1:0] capacity,
  bmms_in_if.sink                         in_ch,
  bmms_out_if.source                      out_ch
);

  localparam int WW = $bits(bmms_pkg::level_t);

  typedef enum logic {S_IDLE, S_CALC} state_t;
  typedef enum logic [2:0] {OP_QUERY, OP_PUSH, OP_POP, OP_REJ_PUSH, OP_REJ_POP} op_t;

  state_t st_r, st_nxt;
  op_t    op_r, op_nxt;

  logic [bmms_pkg::CW-1:0]              count_r, count_nxt;
  logic signed [bmms_pkg::DATA_W-1:0]   pv_r, pv_nxt;

  logic                                 out_valid_r, out_valid_nxt;
  logic signed [bmms_pkg::DATA_W-1:0]   top_r, top_nxt;
  logic signed [bmms_pkg::DATA_W-1:0]   min_r, min_nxt;
  logic signed [bmms_pkg::DATA_W-1:0]   max_r, max_nxt;
  logic [bmms_pkg::CNT_W-1:0]           ecnt_r, ecnt_nxt;
  logic                                 empty_r, empty_nxt;
  logic                                 full_r, full_nxt;
  logic [1:0]                           status_r, status_nxt;

  logic [bmms_pkg::XW-1:0]  cap_x, depth_x, effcap, count_x, new_x;
  logic                     acc, go;
  logic                     ram_we, ram_re;
  logic [bmms_pkg::AW-1:0]  ram_raddr, ram_waddr;
  logic [bmms_pkg::CW-1:0]  raddr_full;
  logic [WW-1:0]            ram_wdata, ram_rdata;
  bmms_pkg::level_t         rd_lvl, wr_lvl;
  logic signed [bmms_pkg::DATA_W-1:0] lmin, lmax;

  // effective capacity: register clipped to the physical depth
  assign cap_x   = bmms_pkg::XW'(capacity);
  assign depth_x = bmms_pkg::XW'(bmms_pkg::DEPTH);
  assign effcap  = (cap_x > depth_x) ? depth_x : cap_x;
  assign count_x = bmms_pkg::XW'(count_r);

  assign in_ch.ready = (st_r == S_IDLE);
  assign acc = in_ch.valid && in_ch.ready;
  assign go  = (st_r == S_CALC) && (!out_valid_r || out_ch.ready);

  // accept: classify and launch the read of the level that becomes/stays visible
  always_comb begin
    op_nxt     = op_r;
    pv_nxt     = pv_r;
    raddr_full = count_r - bmms_pkg::CW'(1);
    if (acc) begin
      pv_nxt = in_ch.push_value;
      case (in_ch.action)
        bmms_pkg::ACT_PUSH: op_nxt = (count_x < effcap) ? OP_PUSH : OP_REJ_PUSH;
        bmms_pkg::ACT_POP: begin
          op_nxt     = (count_r != '0) ? OP_POP : OP_REJ_POP;
          raddr_full = count_r - bmms_pkg::CW'(2);
        end
        default: op_nxt = OP_QUERY;
      endcase
    end
  end

  assign ram_re    = acc;
  assign ram_raddr = raddr_full[bmms_pkg::AW-1:0];
  assign rd_lvl    = bmms_pkg::level_t'(ram_rdata);

  // min/max of the new level against the one below it
  always_comb begin
    lmin = pv_r;
    lmax = pv_r;
    if (count_r != '0) begin
      if (rd_lvl.lmin < pv_r) lmin = rd_lvl.lmin;
      if (rd_lvl.lmax > pv_r) lmax = rd_lvl.lmax;
    end
  end

  assign wr_lvl    = '{val: pv_r, lmin: lmin, lmax: lmax};
  assign ram_wdata = wr_lvl;
  assign ram_waddr = count_r[bmms_pkg::AW-1:0];
  assign ram_we    = go && (op_r == OP_PUSH);

  always_comb begin
    st_nxt        = st_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    top_nxt       = top_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    ecnt_nxt      = ecnt_r;
    empty_nxt     = empty_r;
    full_nxt      = full_r;
    status_nxt    = status_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      S_IDLE: begin
        if (acc) st_nxt = S_CALC;
      end
      S_CALC: begin
        if (go) begin
          status_nxt = bmms_pkg::ST_OK;
          case (op_r)
            OP_PUSH:     count_nxt  = count_r + bmms_pkg::CW'(1);
            OP_POP:      count_nxt  = count_r - bmms_pkg::CW'(1);
            OP_REJ_PUSH: status_nxt = bmms_pkg::ST_FULL;
            OP_REJ_POP:  status_nxt = bmms_pkg::ST_EMPTY;
            default:     count_nxt  = count_r;
          endcase
          if (op_r == OP_PUSH) begin
            top_nxt = pv_r;
            min_nxt = lmin;
            max_nxt = lmax;
          end else if (count_nxt != '0) begin
            top_nxt = rd_lvl.val;
            min_nxt = rd_lvl.lmin;
            max_nxt = rd_lvl.lmax;
          end else begin
            top_nxt = '0;
            min_nxt = bmms_pkg::INT_MAX;
            max_nxt = bmms_pkg::INT_MIN;
          end
          ecnt_nxt      = bmms_pkg::CNT_W'(count_nxt);
          empty_nxt     = (count_nxt == '0);
          full_nxt      = (new_x >= effcap);
          out_valid_nxt = 1'b1;
          st_nxt        = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign new_x = bmms_pkg::XW'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      op_r        <= OP_QUERY;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      op_r        <= op_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pv_r     <= pv_nxt;
    top_r    <= top_nxt;
    min_r    <= min_nxt;
    max_r    <= max_nxt;
    ecnt_r   <= ecnt_nxt;
    empty_r  <= empty_nxt;
    full_r   <= full_nxt;
    status_r <= status_nxt;
  end

  bmms_ram #(
    .WIDTH (WW),
    .DEPTH (bmms_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.top_value   = top_r;
  assign out_ch.entry_count = ecnt_r;
  assign out_ch.is_empty    = empty_r;
  assign out_ch.is_full     = full_r;
  assign out_ch.min_value   = min_r;
  assign out_ch.max_value   = max_r;
  assign out_ch.status      = status_r;

  `BMMS_ASSERT_NOW(a_count_in_range, 1'b1, count_x <= depth_x, "fill count above depth")
  `BMMS_ASSERT_NEXT(a_accept_to_calc, acc, st_r == S_CALC, "accept did not start a step")
  `BMMS_ASSERT_NEXT(a_push_grows, ram_we, count_r == $past(count_r) + bmms_pkg::CW'(1),
                    "push write without count increment")
  `BMMS_ASSERT_NOW(a_reject_full, out_valid_r && status_r == bmms_pkg::ST_FULL, full_r,
                   "push rejected while not full")
  `BMMS_ASSERT_NOW(a_reject_empty, out_valid_r && status_r == bmms_pkg::ST_EMPTY, empty_r,
                   "pop rejected while not empty")

endmodule

`default_nettype wire

FILE: rtl/core/bounded_min_max_stack.sv
// Timing: an accepted item moves the sequencer from IDLE to CALC; its result
//   is registered on leaving CALC, which waits while an older result is held.
// No new item is taken until the last result is registered; the single stack
//   RAM is read (the level under the top), then merged and written back.
// Reset (rst_n low, synchronous): stack empty, capacity 5, no result pending.
//   The stack RAM is not cleared; only levels below the fill count are used.
// ----------------------------------------------------------------------------
// bounded_min_max_stack
// Bounded stack of signed 32-bit values with per-level min/max tracking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_min_max_stack (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // stack items in, results out
  bmms_in_if.sink                            in_ch,
  bmms_out_if.source                         out_ch,
  // APB configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bmms_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [bmms_pkg::CFG_DW-1:0]   pwdata,
  output logic      [bmms_pkg::CFG_DW-1:0]   prdata,
  output logic                               pready
);

  // Each RAM word holds one stack level: the value and the min/max of all
  // values at or below it, so the top word alone answers min and max.
  // A push reads level n-1 on accept, then merges and writes level n on leaving
  // CALC; the next read is launched only after that write, back in IDLE, so no
  // forwarding is needed between steps.
  logic [bmms_pkg::CAP_W-1:0] capacity;

  bmms_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  // Capacity above the depth clips to the depth; capacity zero rejects all
  // pushes and reports full and empty together.
  bmms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .capacity (capacity),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire
